[design/mis_pkg.sv]
// ----------------------------------------------------------------------------
// mis_pkg
// shared constants and types for the merge insertion sorter
// ----------------------------------------------------------------------------
package mis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 31;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;    // insert value this cycle
    logic             shift;  // move contents one place towards cell 0
    logic [VAL_W-1:0] value;  // value being inserted
  } cell_ctrl_t;

endpackage

[design/mis_cell.sv]
// ----------------------------------------------------------------------------
// mis_cell
// one slot of the sorted chain: compares, keeps, takes from a neighbour
// ----------------------------------------------------------------------------
module mis_cell (
  input  logic                          clk,
  input  mis_pkg::cell_ctrl_t           ctrl,
  input  logic                          occ,       // slot holds a list item
  input  logic                          left_gt,   // left neighbour yields to value
  input  logic [mis_pkg::VAL_W-1:0]     left_val,
  input  logic [mis_pkg::VAL_W-1:0]     right_val,
  output logic                          gt,        // this slot yields to value
  output logic [mis_pkg::VAL_W-1:0]     val
);

  logic [mis_pkg::VAL_W-1:0] val_r;
  logic [mis_pkg::VAL_W-1:0] val_nxt;

  // empty slots count as greater than anything; equal values stay ahead
  assign gt  = !occ || (val_r > ctrl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && gt) begin
      val_nxt = left_gt ? left_val : ctrl.value;
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[design/merge_insertion_sorter_top.sv]
// ----------------------------------------------------------------------------
// merge_insertion_sorter_top
// collects a list one request per cycle, keeps it sorted, emits it ascending
// ----------------------------------------------------------------------------
// first result: offered in the cycle after the request marked tlast is taken
// throughput: one input request per cycle while collecting; the run is then
//   drained at one result per cycle while out_tready is high
// the chain of cells sets both rates: insertion uses ins, the drain its shift
// reset (rst_n low, synchronous) empties the list and clears the drop flag
// ----------------------------------------------------------------------------
module merge_insertion_sorter_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value, [31] zero fill
  input  logic        in_tlast,   // last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] value_res, [31] zero fill
  output logic        out_tlast,  // last_res
  output logic [0:0]  out_tuser   // [0] dropped
);

  localparam int N = mis_pkg::MAX_ITEMS;
  localparam int W = mis_pkg::VAL_W;
  localparam int C = mis_pkg::CNT_W;

  // control state
  logic [C-1:0] count_r, count_nxt;
  logic         ovf_r, ovf_nxt;
  logic         drain_r, drain_nxt;

  logic in_acc, out_acc, room;
  mis_pkg::cell_ctrl_t ctrl;

  // neighbour links along the chain
  logic [W-1:0] val_w [N];
  logic         gt_w  [N];

  assign in_tready = !drain_r;        // collecting phase only
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign room      = count_r < C'(N);

  assign ctrl.ins   = in_acc && room;
  assign ctrl.shift = out_acc;
  assign ctrl.value = in_tdata[W-1:0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic         l_gt;
      logic [W-1:0] l_val;
      logic [W-1:0] r_val;
      if (g == 0) begin : g_first
        assign l_gt  = 1'b0;
        assign l_val = '0;
      end else begin : g_mid
        assign l_gt  = gt_w[g-1];
        assign l_val = val_w[g-1];
      end
      if (g == N - 1) begin : g_end
        assign r_val = '0;                // empties as the run drains
      end else begin : g_link
        assign r_val = val_w[g+1];
      end
      mis_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (count_r > C'(g)),
        .left_gt   (l_gt),
        .left_val  (l_val),
        .right_val (r_val),
        .gt        (gt_w[g]),
        .val       (val_w[g])
      );
    end
  endgenerate

  // result straight from the head cell, which is a register
  assign out_tvalid   = drain_r;
  assign out_tdata    = {1'b0, val_w[0]};
  assign out_tlast    = (count_r == C'(1));
  assign out_tuser[0] = ovf_r;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    drain_nxt = drain_r;
    if (in_acc) begin
      if (room) begin
        count_nxt = count_r + C'(1);
      end else begin
        ovf_nxt = 1'b1;                   // full: request dropped
      end
      if (in_tlast) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_acc) begin
      count_nxt = count_r - C'(1);
      if (count_r == C'(1)) begin
        drain_nxt = 1'b0;                 // run done, start a fresh list
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      drain_r <= drain_nxt;
    end
  end

  // a draining run always holds at least one item
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> count_r != '0)
    else $error("drain with empty chain");

  // fill level never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= C'(N))
    else $error("item count beyond capacity");

  // after the final result goes the chain is empty and collecting again
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (count_r == '0 && !ovf_r && in_tready))
    else $error("state not cleared after run");

  // a dropped request only happens with a full chain
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !room) |-> count_r == C'(N))
    else $error("drop below capacity");

endmodule
